// ----- rtl/npc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants of the nearest palette color block
// Holds the palette geometry, field widths and the command format passed
// from the front end to the search engine.
// ----------------------------------------------------------------------------
package npc_pkg;

  // palette geometry
  localparam int PALETTE_SIZE = 16;
  localparam int IDX_W        = 4;
  localparam int CNT_W        = 5;
  localparam int CHAN_W       = 8;
  localparam int SQ_W         = 2 * CHAN_W;
  localparam int DIST_W       = 18;

  // command queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // classified command
  typedef struct packed {
    logic             is_query;
    logic [IDX_W-1:0] entry_index;
    rgb_t             color;
  } cmd_t;

  // queue read side seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

`default_nettype wire

// ----- rtl/npc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npc_front: input transfer, classification and command queue
// Takes items on the start/busy handshake, tags each as a palette write or
// a query and holds it in a small queue until the back end takes it.
// ----------------------------------------------------------------------------
module npc_front
  import npc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              in_mode,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [CHAN_W-1:0] in_red,
  input  wire logic [CHAN_W-1:0] in_green,
  input  wire logic [CHAN_W-1:0] in_blue,
  output      q_head_t           head,
  input  wire logic              pop
);

  cmd_t              queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              do_pop;
  cmd_t              cmd_in;

  // classify the incoming item
  always_comb begin
    cmd_in.is_query    = (in_mode == MODE_QUERY);
    cmd_in.entry_index = in_entry_index;
    cmd_in.color.red   = in_red;
    cmd_in.color.green = in_green;
    cmd_in.color.blue  = in_blue;
  end

  assign busy   = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = queue_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wp_r] <= cmd_in;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/npc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npc_back: palette store and nearest entry search
// Executes queued commands: writes go to the palette, queries scan the
// active entries one per cycle through a read, square and compare pipeline.
// ----------------------------------------------------------------------------
module npc_back
  import npc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CNT_W-1:0]  num_colors,
  input  wire q_head_t           head,
  output      logic              pop,
  output      logic              out_valid,
  output      logic              out_found,
  output      logic [IDX_W-1:0]  out_best_index,
  output      logic [CHAN_W-1:0] out_best_red,
  output      logic [CHAN_W-1:0] out_best_green,
  output      logic [CHAN_W-1:0] out_best_blue,
  output      logic [DIST_W-1:0] out_best_distance
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t            state_r;
  rgb_t              palette_r [PALETTE_SIZE];
  rgb_t              pixel_r;
  logic [CNT_W-1:0]  limit_r;
  logic [IDX_W-1:0]  scan_r;
  logic [CNT_W-1:0]  limit_sat;
  logic              scan_last;

  // read stage
  logic              rd_valid_r;
  logic              rd_first_r;
  logic              rd_last_r;
  logic [IDX_W-1:0]  rd_idx_r;
  rgb_t              rd_data_r;

  // square stage
  logic              sq_valid_r;
  logic              sq_first_r;
  logic              sq_last_r;
  logic [IDX_W-1:0]  sq_idx_r;
  rgb_t              sq_color_r;
  logic [SQ_W-1:0]   sq_red_r;
  logic [SQ_W-1:0]   sq_green_r;
  logic [SQ_W-1:0]   sq_blue_r;
  logic [CHAN_W-1:0] diff_red;
  logic [CHAN_W-1:0] diff_green;
  logic [CHAN_W-1:0] diff_blue;

  // compare stage
  logic [DIST_W-1:0] dist_sum;
  logic              take;
  logic [DIST_W-1:0] best_d_r;
  logic [IDX_W-1:0]  best_idx_r;
  rgb_t              best_color_r;
  logic [DIST_W-1:0] best_d_nxt;
  logic [IDX_W-1:0]  best_idx_nxt;
  rgb_t              best_color_nxt;

  // output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [IDX_W-1:0]  out_idx_r;
  rgb_t              out_color_r;
  logic [DIST_W-1:0] out_dist_r;

  // active count saturated to the palette size
  assign limit_sat = (num_colors > CNT_W'(PALETTE_SIZE)) ? CNT_W'(PALETTE_SIZE) : num_colors;
  assign scan_last = ({1'b0, scan_r} == (limit_r - 1'b1));

  // take a command only once the scan pipeline has drained
  assign pop = head.valid && (state_r == ST_IDLE) && !rd_valid_r && !sq_valid_r;

  // palette store and registered read
  always_ff @(posedge clk) begin
    if (pop && !head.cmd.is_query) begin
      palette_r[head.cmd.entry_index] <= head.cmd.color;
    end
    rd_data_r <= palette_r[scan_r];
  end

  // sequencer: command dispatch and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          scan_r <= '0;
          if (pop && head.cmd.is_query && (limit_sat != '0)) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_valid_r <= 1'b1;
          scan_r     <= scan_r + 1'b1;
          if (scan_last) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // query context and read stage tags
  always_ff @(posedge clk) begin
    if (pop && head.cmd.is_query) begin
      pixel_r <= head.cmd.color;
      limit_r <= limit_sat;
    end
    rd_idx_r   <= scan_r;
    rd_first_r <= (scan_r == '0);
    rd_last_r  <= scan_last;
  end

  // channel differences
  always_comb begin
    diff_red   = (rd_data_r.red >= pixel_r.red) ? rd_data_r.red - pixel_r.red
                                                : pixel_r.red - rd_data_r.red;
    diff_green = (rd_data_r.green >= pixel_r.green) ? rd_data_r.green - pixel_r.green
                                                    : pixel_r.green - rd_data_r.green;
    diff_blue  = (rd_data_r.blue >= pixel_r.blue) ? rd_data_r.blue - pixel_r.blue
                                                  : pixel_r.blue - rd_data_r.blue;
  end

  // square stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else begin
      sq_valid_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_first_r <= rd_first_r;
    sq_last_r  <= rd_last_r;
    sq_idx_r   <= rd_idx_r;
    sq_color_r <= rd_data_r;
    sq_red_r   <= diff_red * diff_red;
    sq_green_r <= diff_green * diff_green;
    sq_blue_r  <= diff_blue * diff_blue;
  end

  // distance sum and running minimum, strict less-than keeps the lowest index
  always_comb begin
    dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);
    take = sq_first_r || (dist_sum < best_d_r);
    best_d_nxt     = take ? dist_sum   : best_d_r;
    best_idx_nxt   = take ? sq_idx_r   : best_idx_r;
    best_color_nxt = take ? sq_color_r : best_color_r;
  end

  always_ff @(posedge clk) begin
    if (sq_valid_r) begin
      best_d_r     <= best_d_nxt;
      best_idx_r   <= best_idx_nxt;
      best_color_r <= best_color_nxt;
    end
  end

  // result register: end of scan, or empty palette answered at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (sq_valid_r && sq_last_r)
                  || (pop && head.cmd.is_query && (limit_sat == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (sq_valid_r && sq_last_r) begin
      out_found_r <= 1'b1;
      out_idx_r   <= best_idx_nxt;
      out_color_r <= best_color_nxt;
      out_dist_r  <= best_d_nxt;
    end else if (pop && head.cmd.is_query) begin
      out_found_r <= 1'b0;
      out_idx_r   <= '0;
      out_color_r <= '0;
      out_dist_r  <= '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_best_index    = out_idx_r;
  assign out_best_red      = out_color_r.red;
  assign out_best_green    = out_color_r.green;
  assign out_best_blue     = out_color_r.blue;
  assign out_best_distance = out_dist_r;

endmodule

`default_nettype wire

// ----- rtl/nearest_palette_color_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_top: nearest palette color search
// Holds a 16-entry RGB palette and finds the closest entry to a pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item transfers on a clock edge with start high and busy low.
//   in_mode 0 writes in_red/in_green/in_blue to palette entry in_entry_index
//   and gives no result; in_mode 1 queries the nearest entry to that pixel.
//   Items pass through a two-entry queue, so busy rises only when it fills.
//   Config: cfg_wr_en writes cfg_wr_data into num_colors; write it only while
//   no item is in flight. Entries 0 to num_colors-1 are searched (at most 16).
//   Output: one result per query, shown for one cycle with out_valid high;
//   the receiver cannot stall. Ties go to the lowest index. An empty palette
//   gives out_found 0 with all other fields zero.
//   Operation: a palette write or an empty-palette query is carried out as
//   soon as it leaves the queue. A query reads the active entries (num_colors
//   capped at 16) one per cycle through a read, square and compare pipeline,
//   and out_valid rises once the last entry has passed the compare stage;
//   the next command can leave the queue once the pipeline has drained, in
//   the cycle in which out_valid is high.
//   Reset: num_colors clears to 0 and the queue empties; palette contents
//   stay undefined until written.
// ----------------------------------------------------------------------------
module nearest_palette_color_top
  import npc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              in_mode,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [CHAN_W-1:0] in_red,
  input  wire logic [CHAN_W-1:0] in_green,
  input  wire logic [CHAN_W-1:0] in_blue,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  output      logic              out_valid,
  output      logic              out_found,
  output      logic [IDX_W-1:0]  out_best_index,
  output      logic [CHAN_W-1:0] out_best_red,
  output      logic [CHAN_W-1:0] out_best_green,
  output      logic [CHAN_W-1:0] out_best_blue,
  output      logic [DIST_W-1:0] out_best_distance
);

  logic [CNT_W-1:0] num_colors_r;
  q_head_t          head;
  logic             pop;

  // num_colors register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_colors_r <= '0;
    end else if (cfg_wr_en) begin
      num_colors_r <= cfg_wr_data;
    end
  end

  // front end: input transfer and command queue
  npc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .head           (head),
    .pop            (pop)
  );

  // back end: palette and search engine
  npc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .num_colors        (num_colors_r),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_best_index    (out_best_index),
    .out_best_red      (out_best_red),
    .out_best_green    (out_best_green),
    .out_best_blue     (out_best_blue),
    .out_best_distance (out_best_distance)
  );

endmodule

`default_nettype wire
